>>> design/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int GRAN_BYTES = 16;
  localparam int GRAN_SH    = 4;
  localparam int NGRAN      = HEAP_BYTES / GRAN_BYTES;
  localparam int DEPTH      = NGRAN + 1;
  localparam int IDX_W      = 13;
  localparam int BYTE_W     = 17;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INIT,
    OP_REJ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] arg;   // granules requested / granules freed beyond the header granule
    logic [IDX_W-1:0] zone;  // header granule of a freed zone
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_A_CHK,
    S_U_CHK,
    S_F_WALK,
    S_F_RDP,
    S_F_LINK,
    S_F_LINK2,
    S_F_M1,
    S_F_M2,
    S_RESP
  } state_t;

endpackage

>>> design/first_fit_free_list_allocator_top.sv
// First-fit free-list allocator. One item in flight in the list walker.
// An alloc walks the free list header by header, then walks it again from the head to unlink
// a zone taken whole; a free walks to its ordered insert point, then links and merges.
// The walker pops a new item from the queue only after the last result is loaded.
// Reset: synchronous, active low; heap reads as one free zone, queue and result empty.
module first_fit_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [16:0] in_size_bytes,
  input  logic [16:0] in_address_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [16:0] out_address_out
);
  import ffa_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_not_empty;

  ffa_front u_front (
    .in_valid(in_valid), .in_mode(in_mode), .in_size_bytes(in_size_bytes),
    .in_address_bytes(in_address_bytes), .q_full(q_full), .in_stall(in_stall),
    .q_push(push), .q_cmd(push_cmd)
  );

  ffa_cmdq u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
    .full(q_full), .not_empty(q_not_empty), .head_cmd(head_cmd)
  );

  ffa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_cmd(head_cmd),
    .q_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_address_out(out_address_out)
  );
endmodule

>>> design/ffa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/ffa_front.sv
// Front end: accepts request items, range-checks them and rounds sizes to granules.
// Depends on ffa_pkg.
module ffa_front (
  input  logic                       in_valid,
  input  logic [1:0]                 in_mode,
  input  logic [16:0]                in_size_bytes,
  input  logic [16:0]                in_address_bytes,
  input  logic                       q_full,
  output logic                       in_stall,
  output logic                       q_push,
  output ffa_pkg::cmd_t              q_cmd
);
  import ffa_pkg::*;

  logic [IDX_W:0]   gran_cnt;
  logic [IDX_W-1:0] zone;
  logic [IDX_W-1:0] free_sz;

  always_comb begin
    gran_cnt = (IDX_W+1)'(({1'b0, in_size_bytes} + 18'(GRAN_BYTES - 1)) >> GRAN_SH);
    zone     = IDX_W'(in_address_bytes >> GRAN_SH);
    if (gran_cnt == '0) begin
      free_sz = '0;
    end else if (gran_cnt - 1'b1 > (IDX_W+1)'({IDX_W{1'b1}})) begin
      free_sz = '1;
    end else begin
      free_sz = IDX_W'(gran_cnt - 1'b1);
    end
    q_cmd.op   = OP_REJ;
    q_cmd.arg  = '0;
    q_cmd.zone = zone;
    case (in_mode)
      MODE_ALLOC: begin
        q_cmd.arg = IDX_W'(gran_cnt);
        if (in_size_bytes != '0 && 32'(in_size_bytes) <= HEAP_BYTES) begin
          q_cmd.op = OP_ALLOC;
        end
      end
      MODE_FREE: begin
        q_cmd.arg = free_sz;
        if (32'(in_address_bytes) >= GRAN_BYTES &&
            32'(in_address_bytes >> GRAN_SH) <= NGRAN) begin
          q_cmd.op = OP_FREE;
        end
      end
      MODE_INIT: q_cmd.op = OP_INIT;
      default:   q_cmd.op = OP_REJ;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
endmodule

>>> design/ffa_cmdq.sv
// Two-entry command queue between the front end and the list walker.
// Depends on ffa_pkg.
module ffa_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ffa_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ffa_pkg::cmd_t head_cmd
);
  import ffa_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head_cmd  = ent_r[rp_r];
endmodule

>>> design/ffa_back.sv
// Back end: walks the free list through the header stores and drives the result register.
// Depends on ffa_pkg and ffa_ram.
module ffa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  ffa_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_status,
  output logic [16:0]   out_address_out
);
  import ffa_pkg::*;

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [IDX_W-1:0] arg_r, arg_nxt;
  logic [IDX_W-1:0] z_r, p_r, p_nxt, q_r, q_nxt, prev_r, prev_nxt;
  logic [IDX_W-1:0] pn_r, pn_nxt, zn_r, zn_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] head_size_r, head_next_r;
  logic             rd_head_r, rd_zero_r;
  logic             st_r, st_nxt;
  logic [16:0]      res_r, res_nxt;
  logic             ov_r, ost_r;
  logic [16:0]      oaddr_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             ws_en, wn_en;
  logic [IDX_W-1:0] ws_idx, ws_val, wn_idx, wn_val;
  logic [IDX_W-1:0] ram_size_q, ram_next_q, rsize, rnext;
  logic             ws_ram, wn_ram, load_out;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] rem;

  assign rsize = rd_zero_r ? '0 : (rd_head_r ? head_size_r : ram_size_q);
  assign rnext = rd_zero_r ? '0 : (rd_head_r ? head_next_r : ram_next_q);
  assign ws_ram = ws_en && ws_idx != '0 && 32'(ws_idx) < DEPTH;
  assign wn_ram = wn_en && wn_idx != '0 && 32'(wn_idx) < DEPTH;

  ffa_ram #(.W(IDX_W), .D(DEPTH)) u_size_ram (
    .clk(clk), .we(ws_ram), .waddr(ADDR_W'(ws_idx)), .wdata(ws_val),
    .raddr(ADDR_W'(rd_idx)), .rdata(ram_size_q)
  );
  ffa_ram #(.W(IDX_W), .D(DEPTH)) u_next_ram (
    .clk(clk), .we(wn_ram), .waddr(ADDR_W'(wn_idx)), .wdata(wn_val),
    .raddr(ADDR_W'(rd_idx)), .rdata(ram_next_q)
  );

  always_comb begin
    state_nxt = state_r;
    arg_nxt = arg_r; p_nxt = p_r; q_nxt = q_r; prev_nxt = prev_r;
    pn_nxt = pn_r; zn_nxt = zn_r; cnt_nxt = cnt_r;
    st_nxt = st_r; res_nxt = res_r;
    rd_en = 1'b0; rd_idx = '0;
    ws_en = 1'b0; ws_idx = '0; ws_val = '0;
    wn_en = 1'b0; wn_idx = '0; wn_val = '0;
    q_pop = 1'b0; load_out = 1'b0;
    sum = '0; rem = '0;
    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        st_nxt = 1'b0; res_nxt = '0; cnt_nxt = '0;
        case (op_r)
          OP_ALLOC: begin
            p_nxt = '0; rd_en = 1'b1; rd_idx = '0;
            state_nxt = S_A_CHK;
          end
          OP_FREE: begin
            ws_en = 1'b1; ws_idx = z_r; ws_val = arg_r;
            prev_nxt = '0; rd_en = 1'b1; rd_idx = '0;
            state_nxt = S_F_WALK;
          end
          OP_INIT: state_nxt = S_RESP;
          default: begin
            st_nxt = 1'b1;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_A_CHK: begin
        rem = rsize - arg_r;
        if (arg_r <= rsize) begin
          ws_en = 1'b1; ws_idx = p_r; ws_val = rem;
          res_nxt = 17'(IDX_W'(p_r + rem + 1'b1)) << GRAN_SH;
          state_nxt = S_RESP;
        end else if (p_r != '0 && {1'b0, arg_r} <= {1'b0, rsize} + 1'b1) begin
          pn_nxt = rnext; q_nxt = '0; cnt_nxt = '0;
          rd_en = 1'b1; rd_idx = '0;
          state_nxt = S_U_CHK;
        end else if (rnext == '0 || 32'(cnt_r) == DEPTH - 1) begin
          st_nxt = 1'b1; state_nxt = S_RESP;
        end else begin
          p_nxt = rnext; cnt_nxt = cnt_r + 1'b1;
          rd_en = 1'b1; rd_idx = rnext;
        end
      end
      S_U_CHK: begin
        if (rnext == p_r) begin
          wn_en = 1'b1; wn_idx = q_r; wn_val = pn_r;
          res_nxt = 17'(p_r) << GRAN_SH;
          state_nxt = S_RESP;
        end else if (32'(cnt_r) == DEPTH - 1) begin
          st_nxt = 1'b1; state_nxt = S_RESP;
        end else begin
          q_nxt = rnext; cnt_nxt = cnt_r + 1'b1;
          rd_en = 1'b1; rd_idx = rnext;
        end
      end
      S_F_WALK: begin
        if (rnext < z_r && rnext != '0) begin
          prev_nxt = rnext;
          if (32'(cnt_r) == DEPTH - 1) begin
            state_nxt = S_F_RDP;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            rd_en = 1'b1; rd_idx = rnext;
          end
        end else begin
          state_nxt = S_F_RDP;
        end
      end
      S_F_RDP: begin
        rd_en = 1'b1; rd_idx = prev_r;
        state_nxt = S_F_LINK;
      end
      S_F_LINK: begin
        pn_nxt = rnext; zn_nxt = rnext;
        wn_en = 1'b1; wn_idx = prev_r; wn_val = z_r;
        state_nxt = S_F_LINK2;
      end
      S_F_LINK2: begin
        wn_en = 1'b1; wn_idx = z_r; wn_val = pn_r;
        rd_en = 1'b1; rd_idx = pn_r;
        state_nxt = S_F_M1;
      end
      S_F_M1: begin
        sum = {1'b0, z_r} + {1'b0, arg_r} + 1'b1;
        if (sum == {1'b0, pn_r}) begin
          arg_nxt = arg_r + rsize + 1'b1;
          ws_en = 1'b1; ws_idx = z_r; ws_val = arg_nxt;
          wn_en = 1'b1; wn_idx = z_r; wn_val = rnext;
          zn_nxt = rnext;
        end
        rd_en = 1'b1; rd_idx = prev_r;
        state_nxt = S_F_M2;
      end
      S_F_M2: begin
        sum = {1'b0, prev_r} + {1'b0, rsize} + 1'b1;
        if (sum == {1'b0, z_r}) begin
          ws_en = 1'b1; ws_idx = prev_r; ws_val = rsize + arg_r + 1'b1;
          wn_en = 1'b1; wn_idx = prev_r; wn_val = zn_r;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || !out_stall) begin
          load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_size_r <= IDX_W'(NGRAN);
      head_next_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_START && op_r == OP_INIT) begin
        head_size_r <= IDX_W'(NGRAN);
        head_next_r <= '0;
      end
      if (ws_en && ws_idx == '0) begin
        head_size_r <= ws_val;
      end
      if (wn_en && wn_idx == '0) begin
        head_next_r <= wn_val;
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
    if (q_pop) begin
      op_r <= q_cmd.op;
      arg_r <= q_cmd.arg;
      z_r <= q_cmd.zone;
    end else begin
      arg_r <= arg_nxt;
    end
    p_r <= p_nxt; q_r <= q_nxt; prev_r <= prev_nxt;
    pn_r <= pn_nxt; zn_r <= zn_nxt; cnt_r <= cnt_nxt;
    st_r <= st_nxt; res_r <= res_nxt;
    if (rd_en) begin
      rd_head_r <= rd_idx == '0;
      rd_zero_r <= 32'(rd_idx) >= DEPTH;
    end
    if (load_out) begin
      ost_r   <= st_r;
      oaddr_r <= st_r ? '0 : res_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_address_out = oaddr_r;

  a_ram_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ws_ram |-> 32'(ws_idx) < DEPTH)
    else $error("size store write out of range");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && q_not_empty)
    else $error("queue popped while busy");
  a_load_only_resp: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> state_r == S_RESP)
    else $error("result loaded outside response state");
  a_resp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> state_r == S_IDLE)
    else $error("no return to idle after result");
endmodule

>>> test/tb_first_fit_free_list_allocator_top.sv
// Testbench for the first-fit free-list allocator: directed edge cases, then random churn.
// Depends on ffa_pkg and first_fit_free_list_allocator_top; prediction is self-contained.
module tb_first_fit_free_list_allocator_top;
  import ffa_pkg::*;

  localparam int IDLE_LIMIT = 50000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic        status;
    logic [16:0] addr;
  } alloc_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_INIT;
  logic [16:0] in_size_bytes = '0;
  logic [16:0] in_address_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [16:0] out_address_out;

  // predictor copy of the header stores
  logic [IDX_W-1:0] hdr_size [0:DEPTH-1];
  logic [IDX_W-1:0] hdr_next [0:DEPTH-1];

  alloc_resp_t resp_q[$];
  logic [16:0] live_addr[$];
  logic [16:0] live_bytes[$];

  int errors = 0;
  int items_sent = 0;
  int resp_seen = 0;
  int allocs_ok = 0;
  int frees_ok = 0;
  int idle_cnt = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  first_fit_free_list_allocator_top DUT (.*);

  always #5 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void heap_reinit();
    hdr_size[0] = IDX_W'(NGRAN);
    hdr_next[0] = '0;
  endfunction

  function automatic int rd_sz(int i);
    return (i >= 0 && i < DEPTH) ? int'(hdr_size[i]) : 0;
  endfunction

  function automatic int rd_nx(int i);
    return (i >= 0 && i < DEPTH) ? int'(hdr_next[i]) : 0;
  endfunction

  function automatic void wr_sz(int i, int v);
    if (i >= 0 && i < DEPTH) hdr_size[i] = IDX_W'(v);
  endfunction

  function automatic void wr_nx(int i, int v);
    if (i >= 0 && i < DEPTH) hdr_next[i] = IDX_W'(v);
  endfunction

  function automatic logic first_fit(int bytes, output int addr);
    int req, p, sz, q;
    addr = 0;
    if (bytes == 0 || bytes > HEAP_BYTES) return 1'b1;
    req = (bytes + GRAN_BYTES - 1) / GRAN_BYTES;
    p = 0;
    for (int n = 0; n < DEPTH; n++) begin
      sz = rd_sz(p);
      if (req <= sz) begin
        sz -= req;
        wr_sz(p, sz);
        addr = (p + sz + 1) * GRAN_BYTES;
        return 1'b0;
      end
      // whole non-head zone fits only with its header counted: unlink it
      if (p != 0 && req <= sz + 1) begin
        q = 0;
        for (int k = 0; k < DEPTH; k++) begin
          if (rd_nx(q) == p) begin
            wr_nx(q, rd_nx(p));
            addr = p * GRAN_BYTES;
            return 1'b0;
          end
          q = rd_nx(q);
        end
        return 1'b1;
      end
      p = rd_nx(p);
      if (p == 0) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic release_zone(int addr, int bytes);
    int z, s, prev, nx;
    if (addr < GRAN_BYTES) return 1'b1;
    z = addr / GRAN_BYTES;
    if (z > NGRAN) return 1'b1;
    s = (bytes + GRAN_BYTES - 1) / GRAN_BYTES;
    s = (s == 0) ? 0 : s - 1;
    if (s > 8191) s = 8191;
    wr_sz(z, s);
    prev = 0;
    for (int k = 0; k < DEPTH; k++) begin
      nx = rd_nx(prev);
      if (!(nx < z && nx != 0)) break;
      prev = nx;
    end
    wr_nx(z, rd_nx(prev));
    wr_nx(prev, z);
    nx = rd_nx(z);
    if (z + 1 + rd_sz(z) == nx) begin
      wr_sz(z, rd_sz(z) + 1 + rd_sz(nx));
      wr_nx(z, rd_nx(nx));
    end
    nx = rd_nx(prev);
    if (prev + 1 + rd_sz(prev) == nx) begin
      wr_sz(prev, rd_sz(prev) + 1 + rd_sz(nx));
      wr_nx(prev, rd_nx(nx));
    end
    return 1'b0;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [16:0] size, logic [16:0] addr);
    alloc_resp_t r;
    int g, a;
    g = rand_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_size_bytes <= size;
    in_address_bytes <= addr;
    do @(posedge clk); while (in_stall);
    items_sent++;
    r.addr = '0;
    case (mode)
      MODE_ALLOC: begin
        r.status = first_fit(int'(size), a);
        if (!r.status) begin
          r.addr = 17'(a);
          live_addr.push_back(17'(a));
          live_bytes.push_back(size);
          allocs_ok++;
        end
      end
      MODE_FREE: begin
        r.status = release_zone(int'(addr), int'(size));
        if (!r.status) frees_ok++;
      end
      MODE_INIT: begin
        heap_reinit();
        live_addr.delete();
        live_bytes.delete();
        r.status = 1'b0;
      end
      default: r.status = 1'b1;
    endcase
    resp_q.push_back(r);
  endtask

  task automatic free_live();
    int i;
    if (live_addr.size() == 0) return;
    i = $urandom_range(0, live_addr.size() - 1);
    send_item(MODE_FREE, live_bytes[i], live_addr[i]);
    live_addr.delete(i);
    live_bytes.delete(i);
  endtask

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, resp_seen);
    errors++;
  endtask

  // result checker, output stall generator and watchdog
  always @(posedge clk) begin
    alloc_resp_t w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL first_fit_free_list_allocator_top");
        $finish;
      end
      if (out_valid && !out_stall) begin
        resp_seen++;
        if (resp_q.size() == 0) begin
          report("unexpected result", out_address_out, 17'd0);
        end else begin
          w = resp_q.pop_front();
          if (out_status !== w.status) report("status", 17'(out_status), 17'(w.status));
          if (out_address_out !== w.addr) report("address", out_address_out, w.addr);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = rand_gap();
      out_stall <= (stall_left > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_size_limits();
    send_item(MODE_ALLOC, 17'd0, 17'd0);
    send_item(MODE_ALLOC, 17'd65537, 17'd0);
    send_item(MODE_ALLOC, 17'h1FFFF, 17'h1FFFF);
    send_item(MODE_ALLOC, 17'd65536, 17'd0);     // whole heap from the head
    send_item(MODE_ALLOC, 17'd1, 17'd0);         // nothing left
    send_item(MODE_INIT, 17'h1FFFF, 17'h1FFFF);
    send_item(MODE_ALLOC, 17'd1, 17'd0);
    send_item(MODE_INIT, 17'd0, 17'd0);
  endtask

  task automatic test_free_edges();
    send_item(MODE_FREE, 17'd16, 17'd0);
    send_item(MODE_FREE, 17'd16, 17'd15);
    send_item(MODE_FREE, 17'd16, 17'd65552);    // past last header slot
    send_item(MODE_FREE, 17'd16, 17'h1FFFF);
    send_item(MODE_UNUSED, 17'h1FFFF, 17'h1FFFF);
    send_item(MODE_ALLOC, 17'd64, 17'd0);
    send_item(MODE_FREE, 17'd64, 17'd65475);    // unaligned, truncated to granule
    send_item(MODE_FREE, 17'd0, 17'd32768);     // zero size
    send_item(MODE_FREE, 17'h1FFFF, 17'd16);    // size saturates
    send_item(MODE_INIT, 17'd0, 17'd0);
  endtask

  task automatic test_unlink();
    logic [16:0] a;
    send_item(MODE_ALLOC, 17'd160, 17'd0);
    a = live_addr[0];
    send_item(MODE_ALLOC, 17'd160, 17'd0);
    send_item(MODE_ALLOC, 17'd65120, 17'd0);    // head left too small for the next one
    send_item(MODE_FREE, 17'd160, a);
    send_item(MODE_ALLOC, 17'd160, 17'd0);      // takes the freed zone whole
    send_item(MODE_INIT, 17'd0, 17'd0);
  endtask

  task automatic test_random_churn(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 19) == 0) send_item(MODE_ALLOC, 17'($urandom_range(1, 65536)), 17'd0);
        else send_item(MODE_ALLOC, 17'($urandom_range(1, 600)), 17'($urandom));
      end else if (r < 88) begin
        free_live();
      end else if (r < 90) begin
        send_item(MODE_INIT, 17'($urandom), 17'($urandom));
      end else if (r < 93) begin
        send_item(MODE_UNUSED, 17'($urandom), 17'($urandom));
      end else begin
        // noise: arbitrary frees, possibly overlapping the live zones
        send_item(MODE_FREE, 17'($urandom), 17'($urandom));
        send_item(MODE_INIT, 17'd0, 17'd0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    heap_reinit();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_size_limits();
    test_free_edges();
    test_unlink();
    test_random_churn(700);
    drain();
    $display("sent %0d items, checked %0d results", items_sent, resp_seen);
    $display("successful allocations %0d, successful frees %0d", allocs_ok, frees_ok);
    if (errors == 0) $display("PASS first_fit_free_list_allocator_top");
    else $display("FAIL first_fit_free_list_allocator_top");
    $finish;
  end

endmodule

>>> sim.f
design/ffa_pkg.sv
design/ffa_ram.sv
design/ffa_front.sv
design/ffa_cmdq.sv
design/ffa_back.sv
design/first_fit_free_list_allocator_top.sv
test/tb_first_fit_free_list_allocator_top.sv
